// ----- sv/gbia_pkg.sv -----
package gbia_pkg;

    localparam int GROUPS       = 16;
    localparam int IPG          = 256;
    localparam int WORD_W       = 64;
    localparam int WPG          = IPG / WORD_W;
    localparam int MAP_WORDS    = GROUPS * WPG;
    localparam int MAP_AW       = $clog2(MAP_WORDS);
    localparam int GRP_W        = $clog2(GROUPS);
    localparam int NG_W         = GRP_W + 1;
    localparam int WSEL_W       = $clog2(WPG);
    localparam int BIT_W        = $clog2(WORD_W);
    localparam int IPG_W        = $clog2(IPG);
    localparam int NUM_W        = 13;
    localparam int CNT_W        = 9;
    localparam int BLK_W        = 16;
    localparam int TOT_W        = 13;
    localparam int DVD_W        = NUM_W + 1;
    localparam int DCNT_W       = $clog2(DVD_W);

    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam logic [TOT_W-1:0] TOT_MAX  = '1;
    localparam logic [CNT_W-1:0] FI_RESET =
        (IPG > 511) ? CNT_MAX : CNT_W'(IPG);

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_BLOCKS = 2'd2;
    localparam logic [1:0] MODE_REPORT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_ISFREE   = 2'd3;

    localparam logic [1:0] CFG_GROUPS  = 2'd0;
    localparam logic [1:0] CFG_FIRST   = 2'd1;
    localparam logic [1:0] CFG_LIMIT   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK1,
        S_MOD,
        S_PROBE,
        S_SCAN,
        S_RD,
        S_CHK,
        S_FREE,
        S_FREE_CHK,
        S_SUM,
        S_OUT
    } t_state;

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

endpackage

// ----- sv/gbia_ram.sv -----
module gbia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/grouped_bitmap_inode_allocator_unit.sv -----
// Report and set-blocks go straight to the totals sweep over the groups in use; free
// first reads and checks one bitmap word unless the number is out of range; allocate
// may first run up to two modulo passes, doubling-step probes, a scan of up to G groups
// and a walk over the bitmap words. One item is taken at a time; the walk reads
// one 64-bit word at a time from the registered-read memory; the modulo unit is serial.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active low) restores the state, configuration and counter
// registers, empties every group and clears the word valid bits, so the bitmap reads as all free at once.
module grouped_bitmap_inode_allocator_unit
    import gbia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [NUM_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [NUM_W-1:0]  i_inode_number_in,
    input  logic [GRP_W-1:0]  i_parent_group,
    input  logic              i_is_dir,
    input  logic [GRP_W-1:0]  i_group_select,
    input  logic [BLK_W-1:0]  i_block_free_count,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [NUM_W-1:0]  o_inode_number_out,
    output logic [GRP_W-1:0]  o_group_chosen,
    output logic [TOT_W-1:0]  o_free_inodes_total,
    output logic [TOT_W-1:0]  o_dirs_total
);

    // Configuration registers.
    logic [NG_W-1:0]  r_groups;
    logic [NUM_W-1:0] r_ff;
    logic [NUM_W-1:0] r_lim;

    // Per-group counters live in flip-flops; the bitmap lives in memory.
    logic [CNT_W-1:0] r_fi  [GROUPS];
    logic [BLK_W-1:0] r_fb  [GROUPS];
    logic [CNT_W-1:0] r_dc  [GROUPS];
    logic [MAP_WORDS-1:0] r_vld;

    t_state r_state, n_state;

    // Latched request.
    logic [1:0]       r_mode;
    logic [NUM_W-1:0] r_num;
    logic [GRP_W-1:0] r_pg;
    logic             r_dir;

    // Search state.
    logic [GRP_W-1:0]  r_g;
    logic [WSEL_W-1:0] r_w;
    logic [NG_W-1:0]   r_k;
    logic [NG_W-1:0]   r_step;
    logic [NG_W-1:0]   r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_mtgt;
    logic [MAP_AW-1:0] r_raddr;

    // Result being built and the totals sweep.
    logic [1:0]       r_status;
    logic [NUM_W-1:0] r_onum;
    logic [GRP_W-1:0] r_ogrp;
    logic [NG_W-1:0]  r_sk;
    logic [TOT_W:0]   r_tf;
    logic [TOT_W:0]   r_td;

    // Output register.
    logic             r_out_valid;
    logic [1:0]       r_o_status;
    logic [NUM_W-1:0] r_o_num;
    logic [GRP_W-1:0] r_o_grp;
    logic [TOT_W-1:0] r_o_tf;
    logic [TOT_W-1:0] r_o_td;

    // Memory port.
    logic              w_ram_we;
    logic [MAP_AW-1:0] w_ram_waddr;
    logic [WORD_W-1:0] w_ram_wdata;
    logic [MAP_AW-1:0] w_ram_raddr;
    logic [WORD_W-1:0] w_ram_rdata;

    logic              w_accept;
    logic [NG_W-1:0]   w_ng;
    logic [NG_W-1:0]   w_rem_sh;
    logic [NG_W-1:0]   w_rem_nx;
    logic [NG_W-1:0]   w_gsum;
    logic [GRP_W-1:0]  w_gn;
    logic [GRP_W-1:0]  w_g_next;
    logic [WORD_W-1:0] w_word;
    logic              w_has_zero;
    logic [BIT_W-1:0]  w_bit;
    logic [NUM_W-1:0]  w_n;
    logic              w_in_range;
    logic [NUM_W-1:0]  w_nm1;
    logic [NUM_W-IPG_W-1:0] w_fgrp;
    logic              w_free_bad;
    logic              w_free_set;
    logic              w_pick1;
    logic              w_probe_hit;
    logic              w_last_word;
    logic              w_last_group;
    logic              w_out_free;

    gbia_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Out-of-range group counts are folded into 1..GROUPS.
    assign w_ng = (r_groups == '0) ? NG_W'(1) :
                  (r_groups > NG_W'(GROUPS)) ? NG_W'(GROUPS) : r_groups;

    // One quotient bit per cycle of a restoring division by the group count.
    assign w_rem_sh = {r_rem[NG_W-2:0], r_dvd[DVD_W-1]};
    assign w_rem_nx = (w_rem_sh >= w_ng) ? (w_rem_sh - w_ng) : w_rem_sh;

    // Probe step that doubles on each probe; both terms are below the group count, so one
    // subtraction wraps it.
    assign w_gsum = {1'b0, r_g} + r_step;
    assign w_gn   = (w_gsum >= w_ng) ? GRP_W'(w_gsum - w_ng) : GRP_W'(w_gsum);
    assign w_g_next = (({1'b0, r_g} + NG_W'(1)) == w_ng) ? '0 : (r_g + GRP_W'(1));

    // A word never written reads as all free.
    assign w_word     = r_vld[r_raddr] ? w_ram_rdata : '0;
    assign w_has_zero = ~&w_word;
    assign w_bit      = lowest_zero(w_word);
    assign w_n        = NUM_W'({r_g, r_w, w_bit}) + NUM_W'(1);
    assign w_in_range = (w_n >= r_ff) && (w_n <= r_lim);

    assign w_nm1      = r_num - NUM_W'(1);
    assign w_fgrp     = w_nm1[NUM_W-1:IPG_W];
    assign w_free_bad = (r_num == '0) || (r_num < r_ff) || (r_num > r_lim) ||
                        (NG_W'(w_fgrp) >= w_ng);
    assign w_free_set = w_word[w_nm1[BIT_W-1:0]];

    assign w_pick1 = ({1'b0, r_pg} < w_ng) && (r_fi[r_pg] != '0) && (r_fb[r_pg] != '0);
    assign w_probe_hit = (r_fi[w_gn] != '0) && (r_fb[w_gn] != '0);
    assign w_last_word  = (r_w == WSEL_W'(WPG - 1));
    assign w_last_group = ((r_k + NG_W'(1)) >= w_ng);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next state and the memory port.
    always_comb begin
        n_state     = r_state;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_raddr;
        w_ram_wdata = w_word;
        w_ram_raddr = {r_g, r_w};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode)
                        MODE_ALLOC: n_state = S_PICK1;
                        MODE_FREE:  n_state = S_FREE;
                        default:    n_state = S_SUM;
                    endcase
                end
            end
            S_PICK1: n_state = w_pick1 ? S_RD : S_MOD;
            S_MOD: begin
                if (r_dcnt == '0) n_state = r_mtgt ? S_SCAN : S_PROBE;
            end
            S_PROBE: begin
                if (r_step >= w_ng)   n_state = S_MOD;
                else if (w_probe_hit) n_state = S_RD;
            end
            S_SCAN: begin
                if (r_k >= w_ng)            n_state = S_SUM;
                else if (r_fi[r_g] != '0)   n_state = S_RD;
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (w_has_zero) begin
                    w_ram_we    = 1'b1;
                    w_ram_wdata = w_word | (WORD_W'(1) << w_bit);
                    n_state     = S_SUM;
                end else if (!w_last_word || !w_last_group) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_FREE: begin
                w_ram_raddr = w_nm1[BIT_W+MAP_AW-1:BIT_W];
                n_state     = w_free_bad ? S_SUM : S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (w_free_set) begin
                    w_ram_we    = 1'b1;
                    w_ram_wdata = w_word & ~(WORD_W'(1) << w_nm1[BIT_W-1:0]);
                end
                n_state = S_SUM;
            end
            S_SUM: begin
                if ((r_sk + NG_W'(1)) >= w_ng) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration, counters and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups <= NG_W'(16);
            r_ff     <= NUM_W'(11);
            r_lim    <= NUM_W'(4096);
            r_vld    <= '0;
            for (int i = 0; i < GROUPS; i++) begin
                r_fi[i] <= FI_RESET;
                r_fb[i] <= '0;
                r_dc[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GROUPS: r_groups <= i_cfg_data[NG_W-1:0];
                    CFG_FIRST:  r_ff     <= i_cfg_data;
                    CFG_LIMIT:  r_lim    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_ram_we) r_vld[w_ram_waddr] <= 1'b1;
            if (w_accept && (i_mode == MODE_BLOCKS)) r_fb[i_group_select] <= i_block_free_count;
            if ((r_state == S_CHK) && w_has_zero && w_in_range) begin
                if (r_fi[r_g] != '0) r_fi[r_g] <= r_fi[r_g] - CNT_W'(1);
                if (r_dir && (r_dc[r_g] != CNT_MAX)) r_dc[r_g] <= r_dc[r_g] + CNT_W'(1);
            end
            if ((r_state == S_FREE_CHK) && w_free_set) begin
                if (r_fi[r_ogrp] != CNT_MAX) r_fi[r_ogrp] <= r_fi[r_ogrp] + CNT_W'(1);
                if (r_dir && (r_dc[r_ogrp] != '0)) r_dc[r_ogrp] <= r_dc[r_ogrp] - CNT_W'(1);
            end
        end
    end

    // Request datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_mode   <= i_mode;
                    r_num    <= i_inode_number_in;
                    r_pg     <= i_parent_group;
                    r_dir    <= i_is_dir;
                    r_status <= (i_mode == MODE_ALLOC) ? ST_NOSPACE : ST_OK;
                    r_onum   <= '0;
                    r_ogrp   <= '0;
                    r_sk     <= '0;
                    r_tf     <= '0;
                    r_td     <= '0;
                end
            end
            S_PICK1: begin
                r_g    <= r_pg;
                r_w    <= '0;
                r_k    <= '0;
                r_rem  <= '0;
                r_dvd  <= DVD_W'(r_pg) + DVD_W'(r_num);
                r_dcnt <= DCNT_W'(DVD_W - 1);
                r_mtgt <= 1'b0;
            end
            S_MOD: begin
                r_rem  <= w_rem_nx;
                r_dvd  <= r_dvd << 1;
                r_dcnt <= r_dcnt - DCNT_W'(1);
                if (r_dcnt == '0) begin
                    r_g    <= GRP_W'(w_rem_nx);
                    r_step <= NG_W'(1);
                    r_k    <= '0;
                end
            end
            S_PROBE: begin
                if (r_step >= w_ng) begin
                    r_rem  <= '0;
                    r_dvd  <= DVD_W'(r_pg) + DVD_W'(1);
                    r_dcnt <= DCNT_W'(DVD_W - 1);
                    r_mtgt <= 1'b1;
                end else begin
                    r_g    <= w_gn;
                    r_step <= r_step << 1;
                    r_w    <= '0;
                    r_k    <= '0;
                end
            end
            S_SCAN: begin
                if (r_fi[r_g] != '0) begin
                    r_w <= '0;
                    r_k <= '0;
                end else begin
                    r_g <= w_g_next;
                    r_k <= r_k + NG_W'(1);
                end
            end
            S_RD: r_raddr <= {r_g, r_w};
            S_CHK: begin
                if (w_has_zero) begin
                    r_ogrp <= r_g;
                    if (w_in_range) begin
                        r_status <= ST_OK;
                        r_onum   <= w_n;
                    end else begin
                        r_status <= ST_RANGE;
                    end
                end else if (!w_last_word) begin
                    r_w <= r_w + WSEL_W'(1);
                end else begin
                    r_w <= '0;
                    r_g <= w_g_next;
                    r_k <= r_k + NG_W'(1);
                end
            end
            S_FREE: begin
                r_raddr <= w_nm1[BIT_W+MAP_AW-1:BIT_W];
                if (w_free_bad) r_status <= ST_RANGE;
                else            r_ogrp   <= GRP_W'(w_fgrp);
            end
            S_FREE_CHK: begin
                if (!w_free_set) r_status <= ST_ISFREE;
            end
            S_SUM: begin
                r_tf <= r_tf + (TOT_W+1)'(r_fi[r_sk[GRP_W-1:0]]);
                r_td <= r_td + (TOT_W+1)'(r_dc[r_sk[GRP_W-1:0]]);
                r_sk <= r_sk + NG_W'(1);
            end
            default: ;
        endcase
    end

    // Output register: loads when the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_o_status <= r_status;
            r_o_num    <= r_onum;
            r_o_grp    <= r_ogrp;
            r_o_tf     <= (r_tf > (TOT_W+1)'(TOT_MAX)) ? TOT_MAX : r_tf[TOT_W-1:0];
            r_o_td     <= (r_td > (TOT_W+1)'(TOT_MAX)) ? TOT_MAX : r_td[TOT_W-1:0];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_o_status;
    assign o_inode_number_out  = r_o_num;
    assign o_group_chosen      = r_o_grp;
    assign o_free_inodes_total = r_o_tf;
    assign o_dirs_total        = r_o_td;

    // The bitmap is only written from the two check states.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_CHK || r_state == S_FREE_CHK))
        else $error("bitmap written outside a check state");

    // Every word read for the allocation walk belongs to a group in use.
    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ({1'b0, r_g} < w_ng))
        else $error("bitmap walk outside the groups in use");

    // An accepted request blocks further transfers in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("second request taken while one is in flight");

    // A successful allocation always carries a nonzero number.
    a_alloc_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && (r_mode == MODE_ALLOC) && (r_status == ST_OK))
            |-> (r_onum != '0))
        else $error("allocation reported ok without a number");

endmodule
